// File: rtl/multi_source_slot_allocator_defines.svh
// assertion helpers for the rtl, included by msa_back
`ifndef MULTI_SOURCE_SLOT_ALLOCATOR_DEFINES_SVH
`define MULTI_SOURCE_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define MSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slot allocator check failed");

// next-cycle implication
`define MSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slot allocator check failed");

`endif

// File: rtl/msa_pkg.sv
package msa_pkg;

    localparam int KIND_W      = 3;
    localparam int SLOT_W      = 12;
    localparam int SEL_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int TOTAL_OUT_W = 13;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_SOURCES = 4;
    localparam int SRC_MAX_W   = 4;
    localparam int GSLOT_MAX_W = 20;

    localparam logic [KIND_W-1:0] KIND_ALLOC       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FREE        = 3'd1;
    localparam logic [KIND_W-1:0] KIND_IO_START    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_IO_DONE     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BEGIN_DRAIN = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ABORT_DRAIN = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_AVAIL = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_INVALID  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_SPACE = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BUSY     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SRC_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SRC_LAST  = 3'd4;

    typedef enum logic [2:0] {
        OP_RESULT,
        OP_ALLOC,
        OP_FREE,
        OP_IO_START,
        OP_IO_DONE,
        OP_DRAIN,
        OP_UNDRAIN
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEL,
        S_RDW,
        S_CHK,
        S_RD,
        S_EXEC,
        S_FIN,
        S_CLR,
        S_CLRD,
        S_CLWR
    } t_state;

    typedef struct packed {
        t_op                    op;
        logic [STATUS_W-1:0]    status;
        logic [SRC_MAX_W-1:0]   src;
        logic [GSLOT_MAX_W-1:0] gslot;
    } t_cmd;

endpackage

// File: rtl/multi_source_slot_allocator.sv
// First-fit slot allocator over up to SOURCES bitmap sources. Items enter a classify
// stage and a two-beat queue, then a sequencer executes them one at a time against
// a bitmap memory (32 slots per word) and a per-slot memory holding the in-flight
// I/O count and pending-release flag. An alloc examines the sources in order, reads
// the bitmap words of the first one with room until a free bit is found, or reports
// no space when no source has room, then hands the beat to the output register;
// free, io_start and io_done read the slot state and then execute, while drain and
// immediate-status items go straight to the result. After reset, and after every slot
// count write, the affected sources are cleared before the next beat is executed:
// first the per-slot memory of a source, then each bitmap word it touches, per source.
// Configuration is taken at any time the block is idle, including during the clear.
module multi_source_slot_allocator #(
    parameter int SOURCES          = 4,
    parameter int SLOTS_PER_SOURCE = 1024,
    parameter int MAX_IO_COUNT     = 15
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [msa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [msa_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [msa_pkg::KIND_W-1:0]      i_kind,
    input  logic [msa_pkg::SLOT_W-1:0]      i_slot_number,
    input  logic [msa_pkg::SEL_W-1:0]       i_source_sel,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [msa_pkg::STATUS_W-1:0]    o_status,
    output logic [msa_pkg::SLOT_W-1:0]      o_granted_slot,
    output logic                            o_released,
    output logic [msa_pkg::TOTAL_OUT_W-1:0] o_free_total
);
    import msa_pkg::*;

    localparam int SW = $clog2(SLOTS_PER_SOURCE + 1);

    logic          enable;
    logic [SW-1:0] slots [SOURCES];
    logic          f_push;
    t_cmd          f_cmd;
    logic          q_ready;
    logic          q_valid;
    t_cmd          q_cmd;
    logic          q_pop;

    msa_front #(
        .SOURCES          (SOURCES),
        .SLOTS_PER_SOURCE (SLOTS_PER_SOURCE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_slot_number (i_slot_number),
        .i_source_sel  (i_source_sel),
        .i_enable      (enable),
        .i_slots       (slots),
        .o_q_push      (f_push),
        .o_q_cmd       (f_cmd),
        .i_q_ready     (q_ready)
    );

    msa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    msa_back #(
        .SOURCES          (SOURCES),
        .SLOTS_PER_SOURCE (SLOTS_PER_SOURCE),
        .MAX_IO_COUNT     (MAX_IO_COUNT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_enable       (enable),
        .o_slots        (slots),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot),
        .o_released     (o_released),
        .o_free_total   (o_free_total)
    );

endmodule

// File: rtl/msa_queue.sv
module msa_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  msa_pkg::t_cmd i_cmd,
    output logic         o_ready,
    output logic         o_valid,
    output msa_pkg::t_cmd o_cmd,
    input  logic         i_pop
);
    import msa_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push_go;
    logic       pop_go;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign push_go = i_push && o_ready;
    assign pop_go  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_go) begin
                r_wp <= ~r_wp;
            end
            if (pop_go) begin
                r_rp <= ~r_rp;
            end
            if (push_go && !pop_go) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop_go && !push_go) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_go) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// File: rtl/msa_front.sv
module msa_front #(
    parameter int SOURCES,
    parameter int SLOTS_PER_SOURCE,
    localparam int SW = $clog2(SLOTS_PER_SOURCE + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [msa_pkg::KIND_W-1:0]     i_kind,
    input  logic [msa_pkg::SLOT_W-1:0]     i_slot_number,
    input  logic [msa_pkg::SEL_W-1:0]      i_source_sel,
    input  logic                           i_enable,
    input  logic [SW-1:0]                  i_slots [SOURCES],
    output logic                           o_q_push,
    output msa_pkg::t_cmd                  o_q_cmd,
    input  logic                           i_q_ready
);
    import msa_pkg::*;

    localparam int LB   = $clog2(SLOTS_PER_SOURCE);
    localparam int SRCW = (SOURCES > 1) ? $clog2(SOURCES) : 1;

    logic            r_valid;
    t_cmd            r_cmd;
    t_cmd            cmd;
    logic [31:0]     s32;
    logic [31:0]     l32;
    logic [31:0]     sel32;
    logic [31:0]     nsl;
    logic [SRCW-1:0] src;
    logic [SRCW-1:0] sel;
    logic            accept;

    assign o_in_stall = r_valid && !i_q_ready;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_q_push   = r_valid;
    assign o_q_cmd    = r_cmd;

    always_comb begin
        s32   = 32'(i_slot_number) >> LB;
        l32   = 32'(i_slot_number) & ((32'd1 << LB) - 32'd1);
        src   = SRCW'(s32);
        sel32 = 32'(i_source_sel);
        sel   = SRCW'(sel32);
        nsl   = 32'(i_slots[src]);
        cmd   = '{op: OP_RESULT, status: STAT_OK, src: '0, gslot: '0};
        if (i_kind > KIND_ABORT_DRAIN) begin
            cmd.status = STAT_INVALID;
        end else if (!i_enable) begin
            cmd.status = STAT_NOT_AVAIL;
        end else begin
            case (i_kind)
                KIND_ALLOC: begin
                    cmd.op = OP_ALLOC;
                end
                KIND_FREE, KIND_IO_START, KIND_IO_DONE: begin
                    if (s32 >= 32'(SOURCES)) begin
                        cmd.status = STAT_INVALID;
                    end else if (nsl == 32'd0 || l32 >= nsl) begin
                        cmd.status = STAT_NOT_AVAIL;
                    end else begin
                        cmd.op    = (i_kind == KIND_FREE)     ? OP_FREE :
                                    (i_kind == KIND_IO_START) ? OP_IO_START : OP_IO_DONE;
                        cmd.src   = SRC_MAX_W'(src);
                        cmd.gslot = GSLOT_MAX_W'(s32 * 32'(SLOTS_PER_SOURCE) + l32);
                    end
                end
                KIND_BEGIN_DRAIN, KIND_ABORT_DRAIN: begin
                    if (sel32 >= 32'(SOURCES)) begin
                        cmd.status = STAT_INVALID;
                    end else if (i_slots[sel] == '0) begin
                        cmd.status = STAT_NOT_AVAIL;
                    end else begin
                        cmd.op  = (i_kind == KIND_BEGIN_DRAIN) ? OP_DRAIN : OP_UNDRAIN;
                        cmd.src = SRC_MAX_W'(sel);
                    end
                end
                default: begin
                    cmd.status = STAT_INVALID;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= cmd;
        end
    end

endmodule

// File: rtl/msa_back.sv
`include "multi_source_slot_allocator_defines.svh"

module msa_back #(
    parameter int SOURCES,
    parameter int SLOTS_PER_SOURCE,
    parameter int MAX_IO_COUNT,
    localparam int SW = $clog2(SLOTS_PER_SOURCE + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [msa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [msa_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                             o_enable,
    output logic [SW-1:0]                    o_slots [SOURCES],
    input  logic                             i_q_valid,
    input  msa_pkg::t_cmd                    i_q_cmd,
    output logic                             o_q_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [msa_pkg::STATUS_W-1:0]     o_status,
    output logic [msa_pkg::SLOT_W-1:0]       o_granted_slot,
    output logic                             o_released,
    output logic [msa_pkg::TOTAL_OUT_W-1:0]  o_free_total
);
    import msa_pkg::*;

    localparam int LB        = $clog2(SLOTS_PER_SOURCE);
    localparam int SRCW      = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int TOTAL     = SOURCES * SLOTS_PER_SOURCE;
    localparam int GW        = $clog2(TOTAL);
    localparam int MAP_WORDS = (TOTAL + 31) / 32;
    localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int TW        = $clog2(TOTAL + 1);
    localparam int CNTW      = $clog2(MAX_IO_COUNT + 1);
    localparam int MW        = CNTW + 1;

    t_state              r_state;
    t_state              n_state;
    t_cmd                r_cmd;
    t_cmd                n_cmd;
    logic [SRCW-1:0]     r_src;
    logic [SRCW-1:0]     n_src;
    logic [WW-1:0]       r_word;
    logic [WW-1:0]       n_word;
    logic [LB-1:0]       r_cidx;
    logic [LB-1:0]       n_cidx;
    logic [SOURCES-1:0]  r_clr_pend;
    logic [SOURCES-1:0]  r_draining;
    logic [SW-1:0]       r_free [SOURCES];
    logic [TW-1:0]       r_total;
    logic [CFG_W-1:0]    r_cfg [CFG_SOURCES];
    logic                r_enable;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SLOT_W-1:0]   r_out_granted;
    logic                r_out_rel;
    logic [TOTAL_OUT_W-1:0] r_out_total;

    logic [31:0]         r_map_mem [MAP_WORDS];
    logic [MW-1:0]       r_meta_mem [TOTAL];
    logic [31:0]         r_map_q;
    logic [MW-1:0]       r_meta_q;

    logic [SW-1:0]       slots [SOURCES];
    logic [SRCW-1:0]     cmd_src;
    logic [GW-1:0]       gaddr;
    logic                can_out;
    logic                eligible;
    logic                last_src;
    logic [31:0]         astart;
    logic [31:0]         cstart;
    logic [31:0]         avail;
    logic [4:0]          first;
    logic                cur_bit;
    logic                pend;
    logic [CNTW-1:0]     cnt;
    logic                clr_last_idx;
    logic                clr_last_word;
    logic [SRCW-1:0]     clr_first;

    logic                map_we;
    logic [31:0]         map_wdata;
    logic                meta_we;
    logic [GW-1:0]       meta_waddr;
    logic [MW-1:0]       meta_wdata;
    logic                fin;
    logic [STATUS_W-1:0] res_status;
    logic [SLOT_W-1:0]   res_granted;
    logic                res_rel;
    logic [TW-1:0]       res_total;
    logic                free_inc;
    logic                free_dec;
    logic [SRCW-1:0]     free_idx;
    logic                drain_set;
    logic                drain_clr;
    logic                clr_start;
    logic [CFG_IDX_W-1:0] cfg_off;
    logic [SRCW-1:0]     cfg_src;
    logic                cfg_src_hit;

    function automatic logic [SW-1:0] sat_slots(input logic [CFG_W-1:0] v);
        if (32'(v) > 32'(SLOTS_PER_SOURCE)) begin
            return SW'(SLOTS_PER_SOURCE);
        end
        return SW'(v);
    endfunction

    function automatic logic [31:0] range_mask(input logic [WW-1:0] w, input logic [31:0] start,
                                               input logic [31:0] len);
        logic [31:0] base;
        logic [31:0] lo;
        logic [31:0] hi;
        base = 32'(w) << 5;
        lo   = (start > base) ? (start - base) : 32'd0;
        hi   = (start + len > base) ? (start + len - base) : 32'd0;
        if (hi > 32'd32) begin
            hi = 32'd32;
        end
        return (32'hFFFF_FFFF << lo) & ~(32'hFFFF_FFFF << hi);
    endfunction

    // saturated slot counts
    always_comb begin
        for (int s = 0; s < SOURCES; s++) begin
            if (s < CFG_SOURCES) begin
                slots[s] = sat_slots(r_cfg[2'(s)]);
            end else begin
                slots[s] = '0;
            end
        end
    end

    assign o_slots  = slots;
    assign o_enable = r_enable;

    always_comb begin
        cmd_src       = SRCW'(r_cmd.src);
        gaddr         = r_cmd.gslot[GW-1:0];
        can_out       = !r_out_valid || !i_out_stall;
        eligible      = (slots[r_src] != '0) && !r_draining[r_src] && (r_free[r_src] != '0);
        last_src      = (r_src == SRCW'(SOURCES - 1));
        astart        = 32'(r_src) * 32'(SLOTS_PER_SOURCE);
        cstart        = astart;
        avail         = ~r_map_q & range_mask(r_word, astart, 32'(slots[r_src]));
        first         = 5'd0;
        for (int b = 31; b >= 0; b--) begin
            if (avail[b]) begin
                first = 5'(b);
            end
        end
        cur_bit       = r_map_q[r_cmd.gslot[4:0]];
        pend          = r_meta_q[MW-1];
        cnt           = r_meta_q[CNTW-1:0];
        clr_last_idx  = (r_cidx == LB'(SLOTS_PER_SOURCE - 1));
        clr_last_word = (32'(r_word) == ((cstart + 32'(SLOTS_PER_SOURCE) - 32'd1) >> 5));
        clr_first     = '0;
        for (int s = SOURCES - 1; s >= 0; s--) begin
            if (r_clr_pend[s]) begin
                clr_first = SRCW'(s);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (|r_clr_pend) begin
                    n_state = S_CLR;
                end else if (i_q_valid) begin
                    case (i_q_cmd.op)
                        OP_ALLOC:                         n_state = S_SEL;
                        OP_FREE, OP_IO_START, OP_IO_DONE: n_state = S_RD;
                        default:                          n_state = S_FIN;
                    endcase
                end
            end
            S_SEL: begin
                if (eligible) begin
                    n_state = S_RDW;
                end else if (last_src) begin
                    n_state = S_FIN;
                end
            end
            S_RDW: n_state = S_CHK;
            S_CHK: begin
                if (avail == '0) begin
                    n_state = S_RDW;
                end else if (can_out) begin
                    n_state = S_IDLE;
                end
            end
            S_RD: n_state = S_EXEC;
            S_EXEC, S_FIN: begin
                if (can_out) begin
                    n_state = S_IDLE;
                end
            end
            S_CLR: begin
                if (clr_last_idx) begin
                    n_state = S_CLRD;
                end
            end
            S_CLRD: n_state = S_CLWR;
            S_CLWR: begin
                if (clr_last_word) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CLRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        o_q_pop     = 1'b0;
        map_we      = 1'b0;
        map_wdata   = r_map_q;
        meta_we     = 1'b0;
        meta_waddr  = gaddr;
        meta_wdata  = '0;
        fin         = 1'b0;
        res_status  = STAT_OK;
        res_granted = '0;
        res_rel     = 1'b0;
        free_inc    = 1'b0;
        free_dec    = 1'b0;
        free_idx    = cmd_src;
        drain_set   = 1'b0;
        drain_clr   = 1'b0;
        clr_start   = 1'b0;
        n_src       = r_src;
        n_word      = r_word;
        n_cidx      = r_cidx;
        n_cmd       = r_cmd;
        case (r_state)
            S_IDLE: begin
                if (|r_clr_pend) begin
                    clr_start = 1'b1;
                    n_src     = clr_first;
                    n_cidx    = '0;
                end else if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_src   = '0;
                    n_word  = WW'(i_q_cmd.gslot >> 5);
                end
            end
            S_SEL: begin
                if (eligible) begin
                    n_word = WW'(astart >> 5);
                end else if (!last_src) begin
                    n_src = r_src + SRCW'(1);
                end
            end
            S_CHK: begin
                if (avail == '0) begin
                    n_word = r_word + WW'(1);
                end else if (can_out) begin
                    fin         = 1'b1;
                    map_we      = 1'b1;
                    map_wdata   = r_map_q | (32'd1 << first);
                    free_dec    = 1'b1;
                    free_idx    = r_src;
                    res_granted = SLOT_W'((32'(r_src) << LB)
                                  | ((32'(r_word) << 5) + 32'(first) - astart));
                end
            end
            S_EXEC: begin
                if (can_out) begin
                    fin = 1'b1;
                    case (r_cmd.op)
                        OP_FREE: begin
                            if (cur_bit) begin
                                if (cnt != '0) begin
                                    meta_we    = 1'b1;
                                    meta_wdata = {1'b1, cnt};
                                end else begin
                                    map_we    = 1'b1;
                                    map_wdata = r_map_q & ~(32'd1 << r_cmd.gslot[4:0]);
                                    free_inc  = 1'b1;
                                    res_rel   = 1'b1;
                                end
                            end
                        end
                        OP_IO_START: begin
                            if (!cur_bit || pend) begin
                                res_status = STAT_INVALID;
                            end else if (32'(cnt) >= 32'(MAX_IO_COUNT)) begin
                                res_status = STAT_BUSY;
                            end else begin
                                meta_we    = 1'b1;
                                meta_wdata = {pend, cnt + CNTW'(1)};
                            end
                        end
                        OP_IO_DONE: begin
                            if (cnt == '0) begin
                                res_status = STAT_INVALID;
                            end else if (cnt == CNTW'(1) && pend) begin
                                meta_we   = 1'b1;
                                map_we    = 1'b1;
                                map_wdata = r_map_q & ~(32'd1 << r_cmd.gslot[4:0]);
                                free_inc  = 1'b1;
                                res_rel   = 1'b1;
                            end else begin
                                meta_we    = 1'b1;
                                meta_wdata = {pend, cnt - CNTW'(1)};
                            end
                        end
                        default: begin
                            res_status = STAT_INVALID;
                        end
                    endcase
                end
            end
            S_FIN: begin
                if (can_out) begin
                    fin = 1'b1;
                    case (r_cmd.op)
                        OP_RESULT: res_status = r_cmd.status;
                        OP_ALLOC:  res_status = STAT_NO_SPACE;
                        OP_DRAIN:  drain_set  = 1'b1;
                        OP_UNDRAIN: begin
                            if (!r_draining[cmd_src]) begin
                                res_status = STAT_BUSY;
                            end else begin
                                drain_clr = 1'b1;
                            end
                        end
                        default: res_status = STAT_INVALID;
                    endcase
                end
            end
            S_CLR: begin
                meta_we    = 1'b1;
                meta_waddr = GW'(cstart + 32'(r_cidx));
                n_cidx     = r_cidx + LB'(1);
                if (clr_last_idx) begin
                    n_word = WW'(cstart >> 5);
                end
            end
            S_CLWR: begin
                map_we    = 1'b1;
                map_wdata = r_map_q & ~range_mask(r_word, cstart, 32'(SLOTS_PER_SOURCE));
                if (!clr_last_word) begin
                    n_word = r_word + WW'(1);
                end
            end
            default: begin
                map_we = 1'b0;
            end
        endcase
        if (free_inc) begin
            res_total = r_total + TW'(1);
        end else if (free_dec) begin
            res_total = r_total - TW'(1);
        end else begin
            res_total = r_total;
        end
    end

    assign cfg_off     = i_cfg_index - CFG_IDX_SRC_FIRST;
    assign cfg_src     = SRCW'(cfg_off);
    assign cfg_src_hit = (i_cfg_index >= CFG_IDX_SRC_FIRST) && (i_cfg_index <= CFG_IDX_SRC_LAST)
                         && (32'(cfg_off) < 32'(SOURCES));

    // memories
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[r_word] <= map_wdata;
        end
        r_map_q <= r_map_mem[r_word];
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[meta_waddr] <= meta_wdata;
        end
        r_meta_q <= r_meta_mem[gaddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr_pend  <= '1;
            r_draining  <= '0;
            r_total     <= '0;
            r_enable    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < SOURCES; s++) begin
                r_free[s] <= '0;
            end
            for (int c = 0; c < CFG_SOURCES; c++) begin
                r_cfg[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we && cfg_src_hit) begin
                r_total <= r_total - TW'(r_free[cfg_src]) + TW'(sat_slots(i_cfg_data));
            end else begin
                r_total <= res_total;
            end
            for (int s = 0; s < SOURCES; s++) begin
                if (i_cfg_we && cfg_src_hit && cfg_src == SRCW'(s)) begin
                    r_draining[s] <= 1'b0;
                    r_free[s]     <= sat_slots(i_cfg_data);
                    r_clr_pend[s] <= 1'b1;
                end else begin
                    if (free_inc && free_idx == SRCW'(s)) begin
                        r_free[s] <= r_free[s] + SW'(1);
                    end else if (free_dec && free_idx == SRCW'(s)) begin
                        r_free[s] <= r_free[s] - SW'(1);
                    end
                    if (drain_set && cmd_src == SRCW'(s)) begin
                        r_draining[s] <= 1'b1;
                    end else if (drain_clr && cmd_src == SRCW'(s)) begin
                        r_draining[s] <= 1'b0;
                    end
                    if (clr_start && n_src == SRCW'(s)) begin
                        r_clr_pend[s] <= 1'b0;
                    end
                end
            end
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_IDX_ENABLE) begin
                    r_enable <= i_cfg_data[0];
                end else if (i_cfg_index >= CFG_IDX_SRC_FIRST
                             && i_cfg_index <= CFG_IDX_SRC_LAST) begin
                    r_cfg[2'(cfg_off)] <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_src  <= n_src;
        r_word <= n_word;
        r_cidx <= n_cidx;
        if (fin) begin
            r_out_status  <= res_status;
            r_out_granted <= res_granted;
            r_out_rel     <= res_rel;
            r_out_total   <= TOTAL_OUT_W'(res_total);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_granted_slot = r_out_granted;
    assign o_released     = r_out_rel;
    assign o_free_total   = r_out_total;

    `MSA_ASSERT_IMP(a_clear_blocks_pop, (r_state == S_CLR || r_state == S_CLRD || r_state == S_CLWR), !o_q_pop)
    `MSA_ASSERT_IMP(a_scan_has_room, (r_state == S_CHK), (r_free[r_src] != '0))
    `MSA_ASSERT_NEXT(a_fin_loads_out, fin, r_out_valid)

endmodule

// File: dv/tb_multi_source_slot_allocator.sv
module tb_multi_source_slot_allocator;
    import msa_pkg::*;

    localparam int N_SRC      = 4;
    localparam int SRC_SLOTS  = 1024;
    localparam int IO_MAX     = 15;
    localparam int WDOG_LIMIT = 30000;
    localparam int LONG_HOLD  = 400;

    typedef struct {
        logic [STATUS_W-1:0]    status;
        logic [SLOT_W-1:0]      granted;
        logic                   released;
        logic [TOTAL_OUT_W-1:0] total;
    } t_alloc_res;

    typedef struct {
        logic [KIND_W-1:0]      kind;
        logic [SLOT_W-1:0]      slot;
        logic [SEL_W-1:0]       sel;
        bit                     typed;
        logic [STATUS_W-1:0]    status;
        logic [SLOT_W-1:0]      granted;
        logic                   released;
        logic [TOTAL_OUT_W-1:0] total;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [KIND_W-1:0]      i_kind = '0;
    logic [SLOT_W-1:0]      i_slot_number = '0;
    logic [SEL_W-1:0]       i_source_sel = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b1;
    logic [STATUS_W-1:0]    o_status;
    logic [SLOT_W-1:0]      o_granted_slot;
    logic                   o_released;
    logic [TOTAL_OUT_W-1:0] o_free_total;

    multi_source_slot_allocator DUT (.*);

    always #5 i_clk = ~i_clk;

    // allocator shadow state
    bit                     m_enable;
    logic [10:0]            m_slots_cfg [N_SRC];
    bit                     m_alloc [N_SRC*SRC_SLOTS];
    bit                     m_pending [N_SRC*SRC_SLOTS];
    logic [3:0]             m_io_cnt [N_SRC*SRC_SLOTS];
    bit                     m_draining [N_SRC];
    int unsigned            m_src_free [N_SRC];
    int unsigned            m_total_free;

    t_alloc_res             expected_q[$];
    t_dir_row               typed_q[$];
    int                     errors = 0;
    bit                     in_quiet = 0;
    bit                     out_quiet = 0;
    bit                     hold_req = 0;

    function automatic int unsigned src_capacity(int s);
        return (m_slots_cfg[s] > SRC_SLOTS) ? SRC_SLOTS : int'(m_slots_cfg[s]);
    endfunction

    function automatic void model_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        int s;
        if (idx == CFG_IDX_ENABLE) begin
            m_enable = val[0];
        end else if (idx >= CFG_IDX_SRC_FIRST && idx <= CFG_IDX_SRC_LAST) begin
            s = idx - CFG_IDX_SRC_FIRST;
            m_slots_cfg[s] = val;
            for (int i = 0; i < SRC_SLOTS; i++) begin
                m_alloc[s*SRC_SLOTS+i] = 0;
                m_pending[s*SRC_SLOTS+i] = 0;
                m_io_cnt[s*SRC_SLOTS+i] = 0;
            end
            m_draining[s] = 0;
            m_src_free[s] = src_capacity(s);
            m_total_free = 0;
            for (int k = 0; k < N_SRC; k++) m_total_free += m_src_free[k];
        end
    endfunction

    function automatic void give_back(int s, int g);
        m_alloc[g] = 0;
        m_pending[g] = 0;
        m_src_free[s]++;
        m_total_free++;
    endfunction

    function automatic t_alloc_res predict_slot_op(logic [KIND_W-1:0] kind,
                                                   logic [SLOT_W-1:0] slot,
                                                   logic [SEL_W-1:0] sel);
        t_alloc_res r;
        int s, l, g;
        bit done;
        r.status = STAT_OK;
        r.granted = '0;
        r.released = 1'b0;
        s = slot[11:10];
        l = slot[9:0];
        g = s * SRC_SLOTS + l;
        if (kind > KIND_ABORT_DRAIN) begin
            r.status = STAT_INVALID;
        end else if (!m_enable) begin
            r.status = STAT_NOT_AVAIL;
        end else if (kind == KIND_ALLOC) begin
            r.status = STAT_NO_SPACE;
            done = 0;
            for (int k = 0; k < N_SRC && !done; k++) begin
                if (src_capacity(k) == 0 || m_draining[k] || m_src_free[k] == 0) continue;
                for (int i = 0; i < src_capacity(k); i++) begin
                    if (!m_alloc[k*SRC_SLOTS+i]) begin
                        m_alloc[k*SRC_SLOTS+i] = 1;
                        m_pending[k*SRC_SLOTS+i] = 0;
                        m_src_free[k]--;
                        m_total_free--;
                        r.granted = {k[1:0], i[9:0]};
                        r.status = STAT_OK;
                        done = 1;
                        break;
                    end
                end
            end
        end else if (kind <= KIND_IO_DONE) begin
            if (src_capacity(s) == 0 || l >= src_capacity(s)) begin
                r.status = STAT_NOT_AVAIL;
            end else if (kind == KIND_FREE) begin
                if (m_alloc[g]) begin
                    if (m_io_cnt[g] != 0) begin
                        m_pending[g] = 1;
                    end else begin
                        give_back(s, g);
                        r.released = 1'b1;
                    end
                end
            end else if (kind == KIND_IO_START) begin
                if (!m_alloc[g] || m_pending[g]) r.status = STAT_INVALID;
                else if (m_io_cnt[g] >= IO_MAX) r.status = STAT_BUSY;
                else m_io_cnt[g]++;
            end else begin
                if (m_io_cnt[g] == 0) begin
                    r.status = STAT_INVALID;
                end else begin
                    m_io_cnt[g]--;
                    if (m_io_cnt[g] == 0 && m_pending[g]) begin
                        give_back(s, g);
                        r.released = 1'b1;
                    end
                end
            end
        end else begin
            if (src_capacity(sel) == 0) r.status = STAT_NOT_AVAIL;
            else if (kind == KIND_BEGIN_DRAIN) m_draining[sel] = 1;
            else if (!m_draining[sel]) r.status = STAT_BUSY;
            else m_draining[sel] = 0;
        end
        r.total = m_total_free[12:0];
        return r;
    endfunction

    // input acceptance, output compare, watchdog
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        t_alloc_res e, p;
        t_dir_row t;
        bit moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat status=%0d slot=%0h rel=%0b total=%0d",
                             $time, o_status, o_granted_slot, o_released, o_free_total);
                end else begin
                    e = expected_q.pop_front();
                    if (o_status !== e.status || o_granted_slot !== e.granted ||
                        o_released !== e.released || o_free_total !== e.total) begin
                        errors++;
                        $display("%0t: mismatch exp %0d/%0h/%0b/%0d got %0d/%0h/%0b/%0d",
                                 $time, e.status, e.granted, e.released, e.total,
                                 o_status, o_granted_slot, o_released, o_free_total);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                p = predict_slot_op(i_kind, i_slot_number, i_source_sel);
                if (typed_q.size() != 0) begin
                    t = typed_q.pop_front();
                    if (t.typed) begin
                        p.status = t.status;
                        p.granted = t.granted;
                        p.released = t.released;
                        p.total = t.total;
                    end
                end
                expected_q.push_back(p);
            end
            if (moved) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // result side
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                n = LONG_HOLD;
                hold_req = 0;
            end else if (out_quiet) n = 0;
            else n = $urandom_range(0, 13);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_beat(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                             logic [SEL_W-1:0] sel);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind <= kind;
        i_slot_number <= slot;
        i_source_sel <= sel;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        model_cfg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_sizes(int a, int b, int c, int d);
        cfg_write(CFG_IDX_SRC_FIRST, CFG_W'(a));
        cfg_write(CFG_IDX_W'(CFG_IDX_SRC_FIRST + 1), CFG_W'(b));
        cfg_write(CFG_IDX_W'(CFG_IDX_SRC_FIRST + 2), CFG_W'(c));
        cfg_write(CFG_IDX_SRC_LAST, CFG_W'(d));
    endtask

    function automatic logic [SLOT_W-1:0] pick_held(bit need_io);
        int start, g;
        start = $urandom_range(0, N_SRC*SRC_SLOTS - 1);
        for (int i = 0; i < N_SRC*SRC_SLOTS; i++) begin
            g = (start + i) % (N_SRC*SRC_SLOTS);
            if (m_alloc[g] && (!need_io || m_io_cnt[g] != 0))
                return {g[11:10], g[9:0]};
        end
        return SLOT_W'($urandom_range(0, 4095));
    endfunction

    task automatic random_beats(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 28) send_beat(KIND_ALLOC, SLOT_W'($urandom), SEL_W'($urandom));
            else if (r < 45) send_beat(KIND_FREE, pick_held(0), SEL_W'($urandom));
            else if (r < 65) send_beat(KIND_IO_START, pick_held(0), SEL_W'($urandom));
            else if (r < 78) send_beat(KIND_IO_DONE, pick_held(1), SEL_W'($urandom));
            else if (r < 86) send_beat(KIND_W'($urandom_range(KIND_BEGIN_DRAIN,
                                                              KIND_ABORT_DRAIN)),
                                       SLOT_W'($urandom), SEL_W'($urandom));
            else send_beat(KIND_W'($urandom_range(0, 7)), SLOT_W'($urandom),
                           SEL_W'($urandom));
        end
    endtask

    t_dir_row dir_rows[$];

    function automatic void add_row(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] sl,
                                    logic [SEL_W-1:0] se, bit ty = 0,
                                    logic [STATUS_W-1:0] st = 0, logic [SLOT_W-1:0] gr = 0,
                                    logic rl = 0, logic [TOTAL_OUT_W-1:0] tt = 0);
        t_dir_row d;
        d.kind = k; d.slot = sl; d.sel = se; d.typed = ty;
        d.status = st; d.granted = gr; d.released = rl; d.total = tt;
        dir_rows.push_back(d);
    endfunction

    function automatic void ref_init();
        m_enable = 0;
        m_total_free = 0;
        for (int s = 0; s < N_SRC; s++) begin
            m_slots_cfg[s] = 0;
            m_draining[s] = 0;
            m_src_free[s] = 0;
        end
        for (int g = 0; g < N_SRC*SRC_SLOTS; g++) begin
            m_alloc[g] = 0;
            m_pending[g] = 0;
            m_io_cnt[g] = 0;
        end
    endfunction

    initial begin
        ref_init();
        // disabled after reset
        add_row(KIND_ALLOC, 12'h000, 2'd0, 1, STAT_NOT_AVAIL, 0, 0, 0);
        add_row(3'd7, 12'hFFF, 2'd3, 1, STAT_INVALID, 0, 0, 0);
        // enabled, sizes 4/0/2/0
        add_row(KIND_ALLOC, 12'hFFF, 2'd3, 1, STAT_OK, 12'h000, 0, 5);
        add_row(KIND_ALLOC, 12'h000, 2'd0, 1, STAT_OK, 12'h001, 0, 4);
        add_row(KIND_IO_START, 12'h000, 2'd0);
        add_row(KIND_FREE, 12'h000, 2'd0);
        add_row(KIND_IO_DONE, 12'h000, 2'd0);
        add_row(KIND_FREE, 12'h400, 2'd0, 1, STAT_NOT_AVAIL, 0, 0, 5);
        add_row(KIND_IO_DONE, 12'h001, 2'd0, 1, STAT_INVALID, 0, 0, 5);
        add_row(KIND_BEGIN_DRAIN, 12'h000, 2'd1, 1, STAT_NOT_AVAIL, 0, 0, 5);
        add_row(KIND_ABORT_DRAIN, 12'h000, 2'd0, 1, STAT_BUSY, 0, 0, 5);
        add_row(KIND_IO_START, 12'h003, 2'd0);
        add_row(KIND_BEGIN_DRAIN, 12'h000, 2'd0);
        add_row(KIND_ALLOC, 12'h000, 2'd0);
        add_row(KIND_BEGIN_DRAIN, 12'h000, 2'd0);
        add_row(KIND_ABORT_DRAIN, 12'h000, 2'd0);
        add_row(KIND_FREE, 12'hFFF, 2'd3);
        add_row(KIND_FREE, 12'h803, 2'd2);
        add_row(3'd6, 12'h000, 2'd0);
        for (int i = 0; i < 5; i++) add_row(KIND_ALLOC, 12'h000, 2'd0);
        add_row(KIND_FREE, 12'h003, 2'd0);

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[i]) begin
            if (i == 2) begin
                wait_drained();
                cfg_write(CFG_IDX_ENABLE, CFG_W'(1));
                set_sizes(4, 0, 2, 0);
            end
            typed_q.push_back(dir_rows[i]);
            send_beat(dir_rows[i].kind, dir_rows[i].slot, dir_rows[i].sel);
        end
        wait_drained();

        set_sizes(8, 3, 0, 5);
        random_beats(220);
        wait_drained();

        // largest sizes, with saturation and a long output hold-off
        set_sizes(1024, 2047, 1, 0);
        in_quiet = 1;
        hold_req = 1;
        random_beats(60);
        in_quiet = 0;
        random_beats(60);
        wait_drained();

        cfg_write(CFG_IDX_ENABLE, CFG_W'(0));
        random_beats(30);
        wait_drained();
        cfg_write(CFG_IDX_ENABLE, CFG_W'(1));

        for (int ph = 0; ph < 4; ph++) begin
            set_sizes($urandom_range(0, 12), $urandom_range(0, 12),
                      $urandom_range(1, 12), $urandom_range(0, 12));
            in_quiet = ph[0];
            out_quiet = ph[1];
            random_beats(130);
            wait_drained();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
